// File: rtl/core/oaif_pkg.sv
// ----------------------------------------------------------------------------
// Ordered array package
// Types, codes and constants shared by the ordered array block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package oaif_pkg;

  localparam int unsigned DefCapacity = 64;
  localparam int unsigned DataWidth   = 32;

  // Operation codes carried in the func field.
  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_READ   = 2'd3
  } func_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ORDER   = 3'd1,
    ST_FULL    = 3'd2,
    ST_INDEX   = 3'd3,
    ST_NOSMALL = 3'd4
  } status_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_RD,
    S_INS_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS_PUT,
    S_REM_RD,
    S_REM_WAIT,
    S_REM_DIG,
    S_RD_WAIT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
    logic [5:0]         index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [6:0]         count;
    logic signed [31:0] read_value;
    logic               is_decreasing;
  } out_item_t;

  // Status of the digit test unit.
  typedef struct packed {
    logic busy;
    logic done;
    logic found;
  } dig_status_t;

endpackage

`default_nettype wire

// File: rtl/core/oaif_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oaif_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/core/oaif_digit5.sv
// ----------------------------------------------------------------------------
// Decimal digit five test
// Peels one decimal digit of the magnitude per cycle and flags a five.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oaif_digit5 (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic signed [31:0]        value_i,
  output oaif_pkg::dig_status_t          status_o
);

  logic        busy_q, busy_d;
  logic [31:0] mag_q, mag_d;
  logic [63:0] prod;
  logic [31:0] quot;
  logic [31:0] rem;
  logic        is_five;
  logic        finish;

  // Divide by ten through the reciprocal 0xCCCCCCCD and a shift of 35.
  assign prod    = 64'(mag_q) * 64'h0000_0000_CCCC_CCCD;
  assign quot    = {3'b000, prod[63:35]};
  assign rem     = mag_q - ((quot << 3) + (quot << 1));
  assign is_five = (rem[3:0] == 4'd5);
  assign finish  = busy_q && ((mag_q == 32'd0) || is_five);

  // Next digit or a fresh start.
  always_comb begin
    busy_d = busy_q;
    mag_d  = mag_q;
    if (start_i) begin
      busy_d = 1'b1;
      mag_d  = value_i[31] ? (32'd0 - 32'(value_i)) : 32'(value_i);
    end else if (finish) begin
      busy_d = 1'b0;
    end else if (busy_q) begin
      mag_d = quot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
  end

  assign status_o.busy  = busy_q;
  assign status_o.done  = finish;
  assign status_o.found = finish && (mag_q != 32'd0) && is_five;

endmodule

`default_nettype wire

// File: rtl/core/ordered_array_insert_and_filter_core.sv
// ----------------------------------------------------------------------------
// Ordered array insert and filter core
// Keeps signed entries in a RAM and runs append, ordered insert, digit
// filter and read operations under a small sequencer.
// ----------------------------------------------------------------------------
// One item is taken at a time; the input stalls until its result has been
// registered. Ordered insert reads entries until it finds the first smaller
// one and then moves the tail up by one entry, from the top down. Remove
// reads each entry and runs it through the digit unit, which peels one
// decimal digit per cycle. The RAM has a single read port, and one digit
// unit serves the filter pass.
// Stored entries are undefined after reset; only entries below the count
// are ever read.
`timescale 1ns / 1ps
`default_nettype none

module ordered_array_insert_and_filter_core #(
  parameter int unsigned Capacity = oaif_pkg::DefCapacity
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire oaif_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output oaif_pkg::out_item_t      out_data_o
);

  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned CW = $clog2(Capacity + 1);
  localparam int unsigned XW = (CW > 7) ? CW : 7;
  localparam logic [CW-1:0] CapC = CW'(Capacity);

  oaif_pkg::state_e     state_q, state_d;
  oaif_pkg::in_item_t   req_q, req_d;
  logic [CW-1:0]        count_q, count_d;
  logic                 dec_q, dec_d;
  logic signed [31:0]   last_q, last_d;
  logic [CW-1:0]        ptr_q, ptr_d;
  logic [CW-1:0]        wr_q, wr_d;
  logic [CW-1:0]        pos_q, pos_d;
  logic signed [31:0]   prev_q, prev_d;
  logic                 flag_q, flag_d;
  logic                 newdec_q, newdec_d;
  logic signed [31:0]   cur_q, cur_d;
  logic [2:0]           st_q, st_d;
  logic signed [31:0]   rd_q, rd_d;
  logic                 out_valid_q, out_valid_d;
  oaif_pkg::out_item_t  out_q, out_d;

  logic                 in_xfer;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [31:0]          ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [31:0]          ram_rdata;
  logic signed [31:0]   rdata_s;
  logic                 dig_start;
  oaif_pkg::dig_status_t dig_st;

  assign in_xfer    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != oaif_pkg::S_IDLE);
  assign rdata_s    = $signed(ram_rdata);

  oaif_ram #(
    .Width (oaif_pkg::DataWidth),
    .Depth (Capacity)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  oaif_digit5 u_digit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (dig_start),
    .value_i  (cur_d),
    .status_o (dig_st)
  );

  // Next state and working registers.
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    count_d     = count_q;
    dec_d       = dec_q;
    last_d      = last_q;
    ptr_d       = ptr_q;
    wr_d        = wr_q;
    pos_d       = pos_q;
    prev_d      = prev_q;
    flag_d      = flag_q;
    newdec_d    = newdec_q;
    cur_d       = cur_q;
    st_d        = st_q;
    rd_d        = rd_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      oaif_pkg::S_IDLE: begin
        if (in_xfer) begin
          req_d   = in_data_i;
          state_d = oaif_pkg::S_DISPATCH;
        end
      end
      oaif_pkg::S_DISPATCH: begin
        st_d  = oaif_pkg::ST_OK;
        rd_d  = 32'sd0;
        ptr_d = '0;
        wr_d  = '0;
        state_d = oaif_pkg::S_DONE;
        case (oaif_pkg::func_e'(req_q.func))
          oaif_pkg::FUNC_APPEND: begin
            if (count_q >= CapC) begin
              st_d = oaif_pkg::ST_FULL;
            end else begin
              dec_d   = dec_q && ((count_q == '0) || (last_q > req_q.value));
              last_d  = req_q.value;
              count_d = count_q + CW'(1);
            end
          end
          oaif_pkg::FUNC_INSERT: begin
            if (!dec_q) begin
              st_d = oaif_pkg::ST_ORDER;
            end else begin
              state_d = oaif_pkg::S_INS_RD;
            end
          end
          oaif_pkg::FUNC_REMOVE: begin
            if (dec_q) begin
              st_d = oaif_pkg::ST_ORDER;
            end else begin
              flag_d  = 1'b1;
              state_d = oaif_pkg::S_REM_RD;
            end
          end
          oaif_pkg::FUNC_READ: begin
            if (XW'(req_q.index) >= XW'(count_q)) begin
              st_d = oaif_pkg::ST_INDEX;
            end else begin
              state_d = oaif_pkg::S_RD_WAIT;
            end
          end
          default: begin
            st_d = oaif_pkg::ST_OK;
          end
        endcase
      end
      // Search for the first entry smaller than the new value.
      oaif_pkg::S_INS_RD: begin
        if (ptr_q == count_q) begin
          st_d    = oaif_pkg::ST_NOSMALL;
          state_d = oaif_pkg::S_DONE;
        end else begin
          state_d = oaif_pkg::S_INS_CMP;
        end
      end
      oaif_pkg::S_INS_CMP: begin
        if (req_q.value > rdata_s) begin
          if (count_q >= CapC) begin
            st_d    = oaif_pkg::ST_FULL;
            state_d = oaif_pkg::S_DONE;
          end else begin
            pos_d    = ptr_q;
            wr_d     = count_q;
            newdec_d = (ptr_q == '0) || (prev_q != req_q.value);
            state_d  = oaif_pkg::S_SHIFT_RD;
          end
        end else begin
          prev_d  = rdata_s;
          ptr_d   = ptr_q + CW'(1);
          state_d = oaif_pkg::S_INS_RD;
        end
      end
      // Move the tail up by one entry, from the top down.
      oaif_pkg::S_SHIFT_RD: begin
        if (wr_q == pos_q) begin
          state_d = oaif_pkg::S_INS_PUT;
        end else begin
          state_d = oaif_pkg::S_SHIFT_WR;
        end
      end
      oaif_pkg::S_SHIFT_WR: begin
        wr_d    = wr_q - CW'(1);
        state_d = oaif_pkg::S_SHIFT_RD;
      end
      oaif_pkg::S_INS_PUT: begin
        count_d = count_q + CW'(1);
        dec_d   = newdec_q;
        state_d = oaif_pkg::S_DONE;
      end
      // Filter pass: keep entries without a five and compact them.
      oaif_pkg::S_REM_RD: begin
        if (ptr_q == count_q) begin
          count_d = wr_q;
          dec_d   = flag_q;
          if (wr_q != '0) begin
            last_d = prev_q;
          end
          state_d = oaif_pkg::S_DONE;
        end else begin
          state_d = oaif_pkg::S_REM_WAIT;
        end
      end
      oaif_pkg::S_REM_WAIT: begin
        cur_d   = rdata_s;
        state_d = oaif_pkg::S_REM_DIG;
      end
      oaif_pkg::S_REM_DIG: begin
        if (dig_st.done) begin
          if (!dig_st.found) begin
            if ((wr_q != '0) && !(prev_q > cur_q)) begin
              flag_d = 1'b0;
            end
            prev_d = cur_q;
            wr_d   = wr_q + CW'(1);
          end
          ptr_d   = ptr_q + CW'(1);
          state_d = oaif_pkg::S_REM_RD;
        end
      end
      oaif_pkg::S_RD_WAIT: begin
        rd_d    = rdata_s;
        state_d = oaif_pkg::S_DONE;
      end
      // Hand the result to the output register once it is free.
      oaif_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d         = 1'b1;
          out_d.status        = st_q;
          out_d.count         = 7'(count_q);
          out_d.read_value    = rd_q;
          out_d.is_decreasing = dec_q;
          state_d             = oaif_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = oaif_pkg::S_IDLE;
      end
    endcase
  end

  // RAM and digit unit controls.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(count_q);
    ram_wdata = 32'(req_q.value);
    ram_raddr = AW'(ptr_q);
    dig_start = 1'b0;
    case (state_q)
      oaif_pkg::S_DISPATCH: begin
        ram_raddr = AW'(req_q.index);
        if ((oaif_pkg::func_e'(req_q.func) == oaif_pkg::FUNC_APPEND) &&
            (count_q < CapC)) begin
          ram_we = 1'b1;
        end
      end
      oaif_pkg::S_SHIFT_RD: begin
        ram_raddr = AW'(wr_q - CW'(1));
      end
      oaif_pkg::S_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(wr_q);
        ram_wdata = ram_rdata;
      end
      oaif_pkg::S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(pos_q);
      end
      oaif_pkg::S_REM_WAIT: begin
        dig_start = 1'b1;
      end
      oaif_pkg::S_REM_DIG: begin
        if (dig_st.done && !dig_st.found) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(wr_q);
          ram_wdata = 32'(cur_q);
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= oaif_pkg::S_IDLE;
      count_q     <= '0;
      dec_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dec_q       <= dec_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    last_q   <= last_d;
    ptr_q    <= ptr_d;
    wr_q     <= wr_d;
    pos_q    <= pos_d;
    prev_q   <= prev_d;
    flag_q   <= flag_d;
    newdec_q <= newdec_d;
    cur_q    <= cur_d;
    st_q     <= st_d;
    rd_q     <= rd_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The count never goes beyond the capacity.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapC)
    else $error("entry count beyond capacity");

  // The RAM is never written while the sequencer is idle.
  a_no_idle_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == oaif_pkg::S_IDLE) |-> !ram_we)
    else $error("RAM write while idle");

  // An accepted item always starts the sequencer.
  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == oaif_pkg::S_DISPATCH))
    else $error("accepted item did not start the sequencer");

  // The digit unit is only started when it is free.
  a_digit_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dig_start |-> !dig_st.busy)
    else $error("digit unit restarted while busy");

endmodule

`default_nettype wire
